>>> hdl/tea_pkg.sv
// shared types, constants and round-constant helpers for the tea cipher core
`default_nettype none

package tea_pkg;

  localparam int Rounds = 32;
  localparam int Stages = 2 * Rounds;
  localparam logic [31:0] TeaDelta = 32'h9E37_79B9;
  localparam int CfgIndexWidth = 8;

  // register indexes of the key words
  localparam logic [CfgIndexWidth-1:0] RegKey0 = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] RegKey1 = CfgIndexWidth'(1);
  localparam logic [CfgIndexWidth-1:0] RegKey2 = CfgIndexWidth'(2);
  localparam logic [CfgIndexWidth-1:0] RegKey3 = CfgIndexWidth'(3);

  // direction codes
  localparam logic FuncEncrypt = 1'b0;
  localparam logic FuncDecrypt = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] word_left;
    logic [31:0] word_right;
  } tea_block_t;

  typedef struct packed {
    logic [31:0] out_left;
    logic [31:0] out_right;
  } tea_result_t;

  typedef struct packed {
    logic [31:0] k0;
    logic [31:0] k1;
    logic [31:0] k2;
    logic [31:0] k3;
  } tea_key_t;

  // payload carried between pipeline stages
  typedef struct packed {
    logic        func;
    logic [31:0] left;
    logic [31:0] right;
  } tea_lane_t;

  // running sum of encryption round r (counted from 0)
  function automatic logic [31:0] tea_enc_sum(input int r);
    logic [31:0] count;
    count = 32'(r + 1);
    return TeaDelta * count;
  endfunction

  // running sum of decryption round r (counted from 0)
  function automatic logic [31:0] tea_dec_sum(input int r);
    logic [31:0] count;
    count = 32'(Rounds - r);
    return TeaDelta * count;
  endfunction

endpackage

`default_nettype wire

>>> hdl/tea_stage.sv
// one half-round of tea as a registered pipeline stage
`default_nettype none

module tea_stage
  import tea_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        phase,
  input  wire logic [31:0] enc_sum,
  input  wire logic [31:0] dec_sum,
  input  wire tea_key_t    key,
  input  wire logic        valid,
  input  wire tea_lane_t   lane,
  output logic             valid_q,
  output tea_lane_t        lane_q
);

  logic        upd_left;
  logic [31:0] src;
  logic [31:0] sum;
  logic [31:0] ka;
  logic [31:0] kb;
  logic [31:0] mix;
  logic [31:0] dst;
  logic [31:0] dst_next;
  tea_lane_t   lane_next;

  // encryption updates left first, decryption undoes right first
  assign upd_left = (lane.func == phase);
  assign src = upd_left ? lane.right : lane.left;
  assign dst = upd_left ? lane.left : lane.right;
  assign ka  = upd_left ? key.k0 : key.k2;
  assign kb  = upd_left ? key.k1 : key.k3;
  assign sum = (lane.func == FuncDecrypt) ? dec_sum : enc_sum;

  // mixing function of the other half
  assign mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);

  assign dst_next = (lane.func == FuncDecrypt) ? (dst - mix) : (dst + mix);

  always_comb begin
    lane_next = lane;
    if (upd_left) begin
      lane_next.left = dst_next;
    end else begin
      lane_next.right = dst_next;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    lane_q <= lane_next;
  end

endmodule

`default_nettype wire

>>> hdl/tea_block_cipher_core.sv
// A block taken on start appears on result with done after the stage chain
// (one register stage per half-round, 32 rounds). Throughput: one block per
// cycle, set by the fully unrolled stage chain; busy is high only in reset.
// Reset: synchronous, clears the key words to zero and empties the pipeline.
// The receiver cannot stall, so done lasts exactly one cycle per block.
`default_nettype none

module tea_block_cipher_core
  import tea_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire tea_block_t               block,
  output logic                          done,
  output tea_result_t                   result,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [31:0]              cfg_data
);

  tea_key_t  key;
  logic      accept;
  logic      cfg_write;
  logic      valid_chain [Stages+1];
  tea_lane_t lane_chain [Stages+1];

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegKey0: key.k0 <= cfg_data;
        RegKey1: key.k1 <= cfg_data;
        RegKey2: key.k2 <= cfg_data;
        RegKey3: key.k3 <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline entry
  assign valid_chain[0]      = accept;
  assign lane_chain[0].func  = block.func;
  assign lane_chain[0].left  = block.word_left;
  assign lane_chain[0].right = block.word_right;

  // half-round stages
  for (genvar i = 0; i < Stages; i++) begin : g_stage
    localparam logic [31:0] EncSum = tea_enc_sum(i / 2);
    localparam logic [31:0] DecSum = tea_dec_sum(i / 2);
    localparam logic        Phase  = 1'(i % 2);

    tea_stage u_stage (
      .clk     (clk),
      .rst     (rst),
      .phase   (Phase),
      .enc_sum (EncSum),
      .dec_sum (DecSum),
      .key     (key),
      .valid   (valid_chain[i]),
      .lane    (lane_chain[i]),
      .valid_q (valid_chain[i+1]),
      .lane_q  (lane_chain[i+1])
    );
  end

  // result
  assign done             = valid_chain[Stages];
  assign result.out_left  = lane_chain[Stages].left;
  assign result.out_right = lane_chain[Stages].right;

  // every accepted transaction leaves its result after the full depth
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##Stages done)
    else $error("result strobe does not match accepted transaction");

  // key words only change on a configuration write
  a_key_hold: assert property (@(posedge clk) disable iff (rst)
    !cfg_write |=> $stable(key))
    else $error("key changed without a configuration write");

  // a write beyond the key leaves it untouched
  a_key_ignore: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && cfg_index != RegKey0 && cfg_index != RegKey1 &&
     cfg_index != RegKey2 && cfg_index != RegKey3) |=> $stable(key))
    else $error("out of range configuration write altered the key");

endmodule

`default_nettype wire
